// ===== design/pdc_pkg.sv =====
// Shared constants for the PWM period and duty capture block.
// No dependencies; used by every module of the block and by the checker.
package pdc_pkg;

  localparam int COUNTER_BITS_DEF = 16;   // default width of the tick counter
  localparam int CLK_W            = 27;   // width of the clock rate register
  localparam int TICKS_W          = 16;   // width of the period and high time ports
  localparam int DUTY_W           = 7;    // width of the duty port
  localparam int QUEUE_DEPTH_DEF  = 2;    // entries between capture and divider

  localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = CLK_W'(16000000);
  localparam logic [DUTY_W-1:0] DUTY_FULL      = DUTY_W'(100);

endpackage

// ===== design/pdc_front.sv =====
// Edge capture front end: counts ticks, timestamps rise, fall and rise edges.
// Depends on pdc_pkg for defaults; pushes one measurement per rise-fall-rise.
module pdc_front #(
  parameter int COUNTER_BITS = pdc_pkg::COUNTER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick_valid,
  input  logic                      level,
  output logic                      meas_push,
  output logic [COUNTER_BITS-1:0]   meas_period,
  output logic [COUNTER_BITS-1:0]   meas_high
);

  localparam logic [1:0] PH_RISE1 = 2'd0;
  localparam logic [1:0] PH_FALL  = 2'd1;
  localparam logic [1:0] PH_RISE2 = 2'd2;

  logic [COUNTER_BITS-1:0] tick_r, tick_nxt;
  logic [COUNTER_BITS-1:0] rise_r, rise_nxt;
  logic [COUNTER_BITS-1:0] fall_r, fall_nxt;
  logic                    last_r, last_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic                    rising, falling;

  assign rising  = level & ~last_r;
  assign falling = ~level & last_r;

  always_comb begin
    tick_nxt  = tick_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    last_nxt  = last_r;
    phase_nxt = phase_r;
    meas_push = 1'b0;
    if (tick_valid) begin
      last_nxt = level;
      tick_nxt = tick_r + COUNTER_BITS'(1);
      case (phase_r)
        PH_FALL: begin
          if (falling) begin
            fall_nxt  = tick_r;
            phase_nxt = PH_RISE2;
          end
        end
        PH_RISE2: begin
          if (rising) begin
            meas_push = 1'b1;
            phase_nxt = PH_RISE1;
          end
        end
        default: begin
          if (rising) begin
            rise_nxt  = tick_r;
            phase_nxt = PH_FALL;
          end
        end
      endcase
    end
  end

  // period ends at the current tick, high time at the stored fall
  assign meas_period = tick_r - rise_r;
  assign meas_high   = fall_r - rise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      last_r  <= 1'b1;
      phase_r <= PH_RISE1;
      rise_r  <= '0;
      fall_r  <= '0;
    end else begin
      tick_r  <= tick_nxt;
      last_r  <= last_nxt;
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

endmodule

// ===== design/pdc_fifo.sv =====
// Small register queue that decouples the edge capture from the divider.
// Depends on pdc_pkg for the default depth.
module pdc_fifo #(
  parameter int WIDTH = 2 * pdc_pkg::COUNTER_BITS_DEF,
  parameter int DEPTH = pdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/pdc_back.sv =====
// Back end: bit-serial frequency and duty division plus the result register.
// Depends on pdc_pkg for widths and the duty ceiling.
module pdc_back #(
  parameter int COUNTER_BITS = pdc_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [pdc_pkg::CLK_W-1:0]      clock_hz,
  input  logic                           q_empty,
  input  logic [COUNTER_BITS-1:0]        q_period,
  input  logic [COUNTER_BITS-1:0]        q_high,
  output logic                           q_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [pdc_pkg::TICKS_W-1:0]    period_ticks,
  output logic [pdc_pkg::TICKS_W-1:0]    high_ticks,
  output logic [pdc_pkg::CLK_W-1:0]      frequency_hz,
  output logic [pdc_pkg::DUTY_W-1:0]     duty_percent,
  output logic                           zero_period
);

  localparam int CB     = COUNTER_BITS;
  localparam int CLK_W  = pdc_pkg::CLK_W;
  localparam int DUTY_W = pdc_pkg::DUTY_W;
  localparam int TW     = pdc_pkg::TICKS_W;
  localparam int CNT_W  = $clog2(CLK_W);
  localparam int HW     = CB + DUTY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CB-1:0]     per_r, per_nxt;
  logic [CB-1:0]     high_r, high_nxt;
  logic [CLK_W-1:0]  dvd_r, dvd_nxt;
  logic [CLK_W-1:0]  fq_r, fq_nxt;
  logic [CB-1:0]     frem_r, frem_nxt;
  logic [DUTY_W-1:0] dlow_r, dlow_nxt;
  logic [DUTY_W-1:0] dq_r, dq_nxt;
  logic [CB-1:0]     drem_r, drem_nxt;
  logic              sat_r, sat_nxt;
  logic              zero_r, zero_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;

  logic [HW-1:0]     hundred;
  logic [CB:0]       ftry, dtry;
  logic              fge, dge;
  logic [CB+TW-1:0]  per_ext, high_ext;

  // high * 100 as shifts: 64 + 32 + 4
  assign hundred = (HW'(q_high) << 6) + (HW'(q_high) << 5) + (HW'(q_high) << 2);

  assign ftry = {frem_r, dvd_r[CLK_W-1]};
  assign fge  = (ftry >= {1'b0, per_r});
  assign dtry = {drem_r, dlow_r[DUTY_W-1]};
  assign dge  = (dtry >= {1'b0, per_r});

  assign q_pop    = (st_r == ST_IDLE) & ~q_empty;
  assign load_out = (st_r == ST_DONE) & (~out_valid_r | pop);

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    per_nxt  = per_r;
    high_nxt = high_r;
    dvd_nxt  = dvd_r;
    fq_nxt   = fq_r;
    frem_nxt = frem_r;
    dlow_nxt = dlow_r;
    dq_nxt   = dq_r;
    drem_nxt = drem_r;
    sat_nxt  = sat_r;
    zero_nxt = zero_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          per_nxt  = q_period;
          high_nxt = q_high;
          dvd_nxt  = clock_hz;
          fq_nxt   = '0;
          frem_nxt = '0;
          // high < period keeps the duty quotient below 2^7
          drem_nxt = hundred[HW-1:DUTY_W];
          dlow_nxt = hundred[DUTY_W-1:0];
          dq_nxt   = '0;
          sat_nxt  = (q_high >= q_period);
          zero_nxt = (q_period == '0);
          cnt_nxt  = CNT_W'(CLK_W - 1);
          st_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        dvd_nxt  = dvd_r << 1;
        fq_nxt   = {fq_r[CLK_W-2:0], fge};
        frem_nxt = fge ? CB'(ftry - {1'b0, per_r}) : CB'(ftry);
        // duty steps overlap the last quotient bits of the frequency
        if (cnt_r < CNT_W'(DUTY_W)) begin
          dlow_nxt = dlow_r << 1;
          dq_nxt   = {dq_r[DUTY_W-2:0], dge};
          drem_nxt = dge ? CB'(dtry - {1'b0, per_r}) : CB'(dtry);
        end
        if (cnt_r == '0) begin
          st_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign per_ext  = {{TW{1'b0}}, per_r};
  assign high_ext = {{TW{1'b0}}, high_r};

  always_ff @(posedge clk) begin
    if (load_out) begin
      period_ticks <= per_ext[TW-1:0];
      high_ticks   <= high_ext[TW-1:0];
      frequency_hz <= zero_r ? '0 : fq_r;
      duty_percent <= zero_r ? '0 : (sat_r ? pdc_pkg::DUTY_FULL : dq_r);
      zero_period  <= zero_r;
    end
  end

  always_ff @(posedge clk) begin
    per_r  <= per_nxt;
    high_r <= high_nxt;
    dvd_r  <= dvd_nxt;
    fq_r   <= fq_nxt;
    frem_r <= frem_nxt;
    dlow_r <= dlow_nxt;
    dq_r   <= dq_nxt;
    drem_r <= drem_nxt;
    sat_r  <= sat_nxt;
    zero_r <= zero_nxt;
    cnt_r  <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty = ~out_valid_r;

endmodule

// ===== design/pwm_period_duty_capture.sv =====
// PWM period and duty capture: one sample of the measured signal per transfer
// on the input side. Samples are taken on each push while full is low; full
// rises only when all queue entries hold measurements waiting for the divider.
// Each measurement (rise, fall, rise) turns into one result in the bit-serial
// divider: after loading from the queue, 27 restoring steps run for the
// frequency quotient, with the 7 duty steps alongside the last ones; the result
// goes to the output register once that is free or being popped. The output
// register holds one result until popped while the next division proceeds.
// Depends on pdc_pkg, pdc_front, pdc_fifo and pdc_back.
module pwm_period_duty_capture_core #(
  parameter int COUNTER_BITS = pdc_pkg::COUNTER_BITS_DEF,
  parameter int QUEUE_DEPTH  = pdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          in_signal_level,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output logic [pdc_pkg::TICKS_W-1:0]   out_period_ticks,
  output logic [pdc_pkg::TICKS_W-1:0]   out_high_ticks,
  output logic [pdc_pkg::CLK_W-1:0]     out_frequency_hz,
  output logic [pdc_pkg::DUTY_W-1:0]    out_duty_percent,
  output logic                          out_zero_period,
  input  logic                          cfg_wr_en,
  input  logic [pdc_pkg::CLK_W-1:0]     cfg_wr_data
);

  logic [pdc_pkg::CLK_W-1:0]   clock_hz_r;
  logic                        tick_valid;
  logic                        meas_push;
  logic [COUNTER_BITS-1:0]     meas_period, meas_high;
  logic                        q_pop, q_empty, q_full;
  logic [2*COUNTER_BITS-1:0]   q_data;

  assign full       = q_full;
  assign tick_valid = push & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= pdc_pkg::CLOCK_HZ_RESET;
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  pdc_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_valid  (tick_valid),
    .level       (in_signal_level),
    .meas_push   (meas_push),
    .meas_period (meas_period),
    .meas_high   (meas_high)
  );

  pdc_fifo #(
    .WIDTH(2 * COUNTER_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (meas_push),
    .push_data ({meas_period, meas_high}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pdc_back #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .clock_hz     (clock_hz_r),
    .q_empty      (q_empty),
    .q_period     (q_data[2*COUNTER_BITS-1:COUNTER_BITS]),
    .q_high       (q_data[COUNTER_BITS-1:0]),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .period_ticks (out_period_ticks),
    .high_ticks   (out_high_ticks),
    .frequency_hz (out_frequency_hz),
    .duty_percent (out_duty_percent),
    .zero_period  (out_zero_period)
  );

endmodule

// ===== design/pdc_checker.sv =====
// Port-level checks for pwm_period_duty_capture_core, bound to the top level.
// Depends on pdc_pkg for port widths and the duty ceiling.
module pdc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          empty,
  input logic                          pop,
  input logic [pdc_pkg::TICKS_W-1:0]   out_period_ticks,
  input logic [pdc_pkg::TICKS_W-1:0]   out_high_ticks,
  input logic [pdc_pkg::CLK_W-1:0]     out_frequency_hz,
  input logic [pdc_pkg::DUTY_W-1:0]    out_duty_percent,
  input logic                          out_zero_period
);

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result visible right after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_period_ticks)
      && $stable(out_high_ticks) && $stable(out_frequency_hz)
      && $stable(out_duty_percent) && $stable(out_zero_period)))
    else $error("waiting result changed before transfer");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_duty_percent <= pdc_pkg::DUTY_FULL))
    else $error("duty above ceiling");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_zero_period) |-> (out_frequency_hz == '0 && out_duty_percent == '0
      && out_period_ticks == '0))
    else $error("zero period result carries nonzero fields");

endmodule

bind pwm_period_duty_capture_core pdc_checker u_pdc_checker (.*);
